FILE: rtl/core/gif_lzw_decoder_unit_defines.svh
// Assertion macros shared by the GIF LZW decoder RTL.
`ifndef GIF_LZW_DECODER_UNIT_DEFINES_SVH
`define GIF_LZW_DECODER_UNIT_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define GLZW_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("glzw invariant violated");

// Checks that a condition in one cycle leads to another in the next cycle.
`define GLZW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glzw sequence violated");

`endif

FILE: rtl/core/glzw_pkg.sv
// Types and constants of the GIF LZW decoder.
`default_nettype none
package glzw_pkg;

    localparam int STACK_DEPTH = 4096;
    localparam int STACK_AW    = 12;
    localparam int BUF_W       = 24;
    localparam int CODE_MAX_W  = 12;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_PULL  = 2'd1,
        CMD_START = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_PIXEL     = 3'd0,
        STAT_NEED_DATA = 3'd1,
        STAT_ACCEPTED  = 3'd2,
        STAT_REJECTED  = 3'd3,
        STAT_END_CODE  = 3'd4,
        STAT_CIRCULAR  = 3'd5,
        STAT_EXHAUSTED = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_DECODE,
        ST_WALK
    } state_t;

endpackage
`default_nettype wire

FILE: rtl/core/glzw_table.sv
// String table of the LZW decoder: prefix and suffix memories.
`default_nettype none
module glzw_table #(
    parameter int AW = 12
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [AW-1:0] rd_prefix,
    output logic      [7:0]    rd_suffix,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [AW-1:0] wr_prefix,
    input  wire logic [7:0]    wr_suffix
);
    import glzw_pkg::*;

    localparam int DEPTH = 1 << AW;

    logic [AW-1:0] prefix_mem [DEPTH];
    logic [7:0]    suffix_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prefix_mem[wr_addr] <= wr_prefix;
            suffix_mem[wr_addr] <= wr_suffix;
        end
        if (rd_en)
        begin
            rd_prefix <= prefix_mem[rd_addr];
            rd_suffix <= suffix_mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/gif_lzw_decoder_unit.sv
// Push, start and unknown commands answer in the cycle after the transfer.
// A pull that finds pixels on the stack reads it and answers from ST_POP.
// A decoding pull answers after its decode steps in ST_DECODE (a clear code is a step of
// its own); a code that walks the table steps through ST_WALK per entry walked and for the root.
// Reset is asynchronous; the table needs no clearing pass, written entries are
// tracked as the range from the first free code of the last table reset.
`default_nettype none
module gif_lzw_decoder_unit #(
    parameter int MAX_CODE_BITS = 12
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // cmd [1:0], data_byte [9:2], zeros above
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // pixel_index [7:0], status [10:8], zeros above
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_data
);
    import glzw_pkg::*;

    `include "gif_lzw_decoder_unit_defines.svh"

    localparam int AW = MAX_CODE_BITS;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] TABLE_SIZE = CW'(1) << AW;

    state_t state_reg, state_next;
    logic [3:0]          min_size_reg;
    logic [STACK_AW:0]   count_reg, count_next;
    logic [7:0]          first_reg, first_next;
    logic [AW-1:0]       prev_reg, prev_next;
    logic [AW-1:0]       in_code_reg, in_code_next;
    logic [AW-1:0]       c_reg, c_next;
    logic [CW-1:0]       nfc_reg, nfc_next;
    logic [CW-1:0]       base_reg, base_next;
    logic [CW-1:0]       limit_reg, limit_next;
    logic [3:0]          width_reg, width_next;
    logic                await_reg, await_next;
    logic [BUF_W-1:0]    buf_reg, buf_next;
    logic [4:0]          held_reg, held_next;
    logic [7:0]          left_reg, left_next;
    logic                term_reg, term_next;
    logic                ended_reg, ended_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_pix_reg, out_pix_next;
    status_t             out_stat_reg, out_stat_next;

    logic [1:0]  in_cmd;
    logic [7:0]  in_byte;
    logic        s_fire, load_ok;
    logic [3:0]  eff_min;
    logic [CW-1:0] clr;
    logic [CODE_MAX_W-1:0] code12;
    logic [AW-1:0] code;
    logic [CW-1:0] code_ext, c_ext;
    logic        short_bits;
    logic        entry_ok;
    logic [AW-1:0] walk_p;
    logic [7:0]  walk_s;
    logic        c_ge_clr, stk_full, circ;
    logic        finish_req, fin_load;
    logic [7:0]  fin_pix;
    status_t     fin_stat;
    logic        tbl_reset;
    logic [CW-1:0] nfc_inc;

    logic          tbl_rd_en, tbl_wr_en;
    logic [AW-1:0] tbl_rd_addr, tbl_rd_prefix;
    logic [7:0]    tbl_rd_suffix;

    logic                stk_we, stk_re;
    logic [STACK_AW-1:0] stk_waddr, stk_raddr;
    logic [7:0]          stk_wdata, stk_rdata;
    logic [7:0]          stack_mem [STACK_DEPTH];

    assign in_cmd    = s_tdata[1:0];
    assign in_byte   = s_tdata[9:2];
    assign load_ok   = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && load_ok;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {5'd0, out_stat_reg, out_pix_reg};

    always_comb
    begin
        if (min_size_reg < 4'd2)
            eff_min = 4'd2;
        else if (min_size_reg > 4'd8)
            eff_min = 4'd8;
        else
            eff_min = min_size_reg;
    end

    assign clr        = CW'(1) << eff_min;
    assign code12     = buf_reg[CODE_MAX_W-1:0] & ~({CODE_MAX_W{1'b1}} << width_reg);
    assign code       = code12[AW-1:0];
    assign code_ext   = {1'b0, code};
    assign short_bits = held_reg < {1'b0, width_reg};
    assign c_ext      = {1'b0, c_reg};
    assign entry_ok   = (c_ext >= base_reg) && (c_ext < nfc_reg);
    assign walk_p     = entry_ok ? tbl_rd_prefix : '0;
    assign walk_s     = entry_ok ? tbl_rd_suffix : ((c_ext < clr) ? c_reg[7:0] : 8'd0);
    assign c_ge_clr   = c_ext >= clr;
    assign stk_full   = count_reg[STACK_AW];
    assign circ       = stk_full || (walk_p == c_reg);
    assign nfc_inc    = nfc_reg + CW'(1);

    // Decide whether this cycle produces a result, and which.
    always_comb
    begin
        finish_req = 1'b0;
        fin_pix    = 8'd0;
        fin_stat   = STAT_ACCEPTED;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    case (in_cmd)
                        CMD_PUSH:
                        begin
                            finish_req = 1'b1;
                            if (!term_reg && left_reg != 8'd0 && held_reg > 5'd16)
                                fin_stat = STAT_REJECTED;
                        end
                        CMD_PULL:
                        begin
                            if (count_reg == '0 && ended_reg)
                            begin
                                finish_req = 1'b1;
                                fin_stat   = STAT_END_CODE;
                            end
                        end
                        CMD_START: finish_req = 1'b1;
                        default:
                        begin
                            finish_req = 1'b1;
                            fin_stat   = STAT_REJECTED;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                finish_req = 1'b1;
                fin_pix    = stk_rdata;
                fin_stat   = STAT_PIXEL;
            end
            ST_DECODE:
            begin
                if (short_bits)
                begin
                    finish_req = 1'b1;
                    fin_stat   = term_reg ? STAT_EXHAUSTED : STAT_NEED_DATA;
                end
                else if (code_ext == clr)
                    finish_req = 1'b0;
                else if (code_ext == clr + CW'(1))
                begin
                    finish_req = 1'b1;
                    fin_stat   = STAT_END_CODE;
                end
                else if (await_reg)
                begin
                    finish_req = 1'b1;
                    fin_pix    = code[7:0];
                    fin_stat   = STAT_PIXEL;
                end
            end
            ST_WALK:
            begin
                if (!c_ge_clr || circ)
                begin
                    finish_req = 1'b1;
                    if (c_ge_clr || stk_full)
                        fin_stat = STAT_CIRCULAR;
                    else
                    begin
                        fin_pix  = walk_s;
                        fin_stat = STAT_PIXEL;
                    end
                end
            end
            default: finish_req = 1'b0;
        endcase
    end

    // A finishing cycle waits, changing nothing, until the output register is free.
    assign fin_load = finish_req && load_ok;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && in_cmd == CMD_PULL)
                begin
                    if (count_reg != '0)
                        state_next = ST_POP;
                    else if (!ended_reg)
                        state_next = ST_DECODE;
                end
            end
            ST_POP:
                if (load_ok)
                    state_next = ST_IDLE;
            ST_DECODE:
            begin
                if (finish_req)
                begin
                    if (load_ok)
                        state_next = ST_IDLE;
                end
                else if (code_ext != clr)
                    state_next = ST_WALK;
            end
            ST_WALK:
                if (finish_req && load_ok)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next   = count_reg;
        first_next   = first_reg;
        prev_next    = prev_reg;
        in_code_next = in_code_reg;
        c_next       = c_reg;
        nfc_next     = nfc_reg;
        base_next    = base_reg;
        limit_next   = limit_reg;
        width_next   = width_reg;
        await_next   = await_reg;
        buf_next     = buf_reg;
        held_next    = held_reg;
        left_next    = left_reg;
        term_next    = term_reg;
        ended_next   = ended_reg;
        tbl_reset    = 1'b0;
        tbl_rd_en    = 1'b0;
        tbl_rd_addr  = c_reg;
        tbl_wr_en    = 1'b0;
        stk_we       = 1'b0;
        stk_waddr    = count_reg[STACK_AW-1:0];
        stk_wdata    = first_reg;
        stk_re       = 1'b0;
        stk_raddr    = STACK_AW'(count_reg - 1'b1);
        if (!(finish_req && !load_ok))
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        case (in_cmd)
                            CMD_PUSH:
                            begin
                                if (!term_reg)
                                begin
                                    if (left_reg == 8'd0)
                                    begin
                                        if (in_byte == 8'd0)
                                            term_next = 1'b1;
                                        else
                                            left_next = in_byte;
                                    end
                                    else if (held_reg <= 5'd16)
                                    begin
                                        buf_next  = buf_reg | (BUF_W'(in_byte) << held_reg);
                                        held_next = held_reg + 5'd8;
                                        left_next = left_reg - 8'd1;
                                    end
                                end
                            end
                            CMD_PULL:
                            begin
                                if (count_reg != '0)
                                begin
                                    stk_re     = 1'b1;
                                    count_next = count_reg - 1'b1;
                                end
                            end
                            CMD_START:
                            begin
                                tbl_reset  = 1'b1;
                                first_next = 8'd0;
                                prev_next  = '0;
                                buf_next   = '0;
                                held_next  = '0;
                                left_next  = '0;
                                term_next  = 1'b0;
                                ended_next = 1'b0;
                            end
                            default: tbl_reset = 1'b0;
                        endcase
                    end
                end
                ST_DECODE:
                begin
                    if (!short_bits)
                    begin
                        buf_next  = buf_reg >> width_reg;
                        held_next = held_reg - {1'b0, width_reg};
                        if (code_ext == clr)
                            tbl_reset = 1'b1;
                        else if (code_ext == clr + CW'(1))
                            ended_next = 1'b1;
                        else if (await_reg)
                        begin
                            await_next = 1'b0;
                            first_next = code[7:0];
                            prev_next  = code;
                        end
                        else
                        begin
                            in_code_next = code;
                            tbl_rd_en    = 1'b1;
                            if (code_ext >= nfc_reg)
                            begin
                                // Code not yet in the table: the string is the
                                // previous one followed by its own first pixel.
                                stk_we      = 1'b1;
                                count_next  = count_reg + 1'b1;
                                c_next      = prev_reg;
                                tbl_rd_addr = prev_reg;
                            end
                            else
                            begin
                                c_next      = code;
                                tbl_rd_addr = code;
                            end
                        end
                    end
                end
                ST_WALK:
                begin
                    if (c_ge_clr)
                    begin
                        if (circ)
                            count_next = '0;
                        else
                        begin
                            stk_we      = 1'b1;
                            stk_wdata   = walk_s;
                            count_next  = count_reg + 1'b1;
                            c_next      = walk_p;
                            tbl_rd_en   = 1'b1;
                            tbl_rd_addr = walk_p;
                        end
                    end
                    else if (stk_full)
                        count_next = '0;
                    else
                    begin
                        // The root pixel is pushed and popped at once.
                        first_next = walk_s;
                        if (nfc_reg < TABLE_SIZE)
                        begin
                            tbl_wr_en = 1'b1;
                            nfc_next  = nfc_inc;
                            if (nfc_inc >= limit_reg && limit_reg < TABLE_SIZE)
                            begin
                                limit_next = limit_reg << 1;
                                width_next = width_reg + 4'd1;
                            end
                        end
                        prev_next = in_code_reg;
                    end
                end
                default: stk_re = 1'b0;
            endcase
            if (tbl_reset)
            begin
                width_next = eff_min + 4'd1;
                limit_next = clr << 1;
                nfc_next   = clr + CW'(2);
                base_next  = clr + CW'(2);
                count_next = '0;
                await_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_pix_next   = out_pix_reg;
        out_stat_next  = out_stat_reg;
        if (fin_load)
        begin
            out_valid_next = 1'b1;
            out_pix_next   = fin_pix;
            out_stat_next  = fin_stat;
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    glzw_table #(
        .AW (AW)
    ) u_table (
        .clk       (clk),
        .rd_en     (tbl_rd_en),
        .rd_addr   (tbl_rd_addr),
        .rd_prefix (tbl_rd_prefix),
        .rd_suffix (tbl_rd_suffix),
        .wr_en     (tbl_wr_en),
        .wr_addr   (nfc_reg[AW-1:0]),
        .wr_prefix (prev_reg),
        .wr_suffix (walk_s)
    );

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[stk_waddr] <= stk_wdata;
        if (stk_re)
            stk_rdata <= stack_mem[stk_raddr];
    end

    always_ff @(posedge clk)
    begin
        out_pix_reg <= out_pix_next;
        in_code_reg <= in_code_next;
        c_reg       <= c_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            min_size_reg  <= 4'd8;
            count_reg     <= '0;
            first_reg     <= 8'd0;
            prev_reg      <= '0;
            nfc_reg       <= CW'(258);
            base_reg      <= CW'(258);
            limit_reg     <= CW'(512);
            width_reg     <= 4'd9;
            await_reg     <= 1'b1;
            buf_reg       <= '0;
            held_reg      <= '0;
            left_reg      <= '0;
            term_reg      <= 1'b0;
            ended_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_stat_reg  <= STAT_PIXEL;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_valid && cfg_ready)
                min_size_reg <= cfg_data;
            count_reg     <= count_next;
            first_reg     <= first_next;
            prev_reg      <= prev_next;
            nfc_reg       <= nfc_next;
            base_reg      <= base_next;
            limit_reg     <= limit_next;
            width_reg     <= width_next;
            await_reg     <= await_next;
            buf_reg       <= buf_next;
            held_reg      <= held_next;
            left_reg      <= left_next;
            term_reg      <= term_next;
            ended_reg     <= ended_next;
            out_valid_reg <= out_valid_next;
            out_stat_reg  <= out_stat_next;
        end
    end

    `GLZW_ASSERT_ALWAYS(a_stack_bound, count_reg <= (STACK_AW + 1)'(STACK_DEPTH))
    `GLZW_ASSERT_ALWAYS(a_buffer_bound, held_reg <= 5'd24)
    `GLZW_ASSERT_ALWAYS(a_width_bound, width_reg <= 4'(AW) && width_reg >= 4'd3)
    `GLZW_ASSERT_NEXT(a_pop_result, state_reg == ST_POP, out_valid_reg)

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the GIF LZW decoder: directed rows, then random images.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import glzw_pkg::*;

    localparam logic [1:0] CMD_BAD = 2'd3;
    localparam int TBL_SIZE = 4096;
    localparam int ITEM_GOAL = 1250;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [7:0] pix;
        status_t    st;
    } pixel_result_t;

    typedef struct {
        logic [1:0]    cmd;
        logic [7:0]    data;
        bit            typed;
        pixel_result_t res;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = '0;

    gif_lzw_decoder_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // Decoder state mirrored by the predictor.
    logic [11:0] pre_tab [TBL_SIZE];
    logic [7:0]  suf_tab [TBL_SIZE];
    bit          wr_tab  [TBL_SIZE];
    logic [7:0]  pix_stk [TBL_SIZE];
    int          stk_cnt, prev_code, next_free, width_lim, code_w, bits_held, blk_left;
    int          bit_buf;
    logic [7:0]  first_ch;
    bit          await_first, term_seen, stream_done;
    logic [3:0]  min_size;

    pixel_result_t pixel_q[$];
    int fails = 0, items = 0, results = 0, images = 0, cycles = 0;
    int burst_left = 0;

    function automatic int eff_size();
        int m;
        m = min_size;
        if (m < 2) m = 2;
        if (m > 8) m = 8;
        return m;
    endfunction

    task automatic table_clear();
        for (int i = 0; i < TBL_SIZE; i++) wr_tab[i] = 1'b0;
        code_w = eff_size() + 1;
        width_lim = 2 << eff_size();
        next_free = (1 << eff_size()) + 2;
        stk_cnt = 0;
        await_first = 1'b1;
    endtask

    task automatic image_start();
        table_clear();
        first_ch = '0;
        prev_code = 0;
        bit_buf = 0;
        bits_held = 0;
        blk_left = 0;
        term_seen = 1'b0;
        stream_done = 1'b0;
    endtask

    function automatic bit stack_put(logic [7:0] v);
        if (stk_cnt >= TBL_SIZE) return 1'b0;
        pix_stk[stk_cnt] = v;
        stk_cnt++;
        return 1'b1;
    endfunction

    function automatic int prefix_of(int c);
        c &= TBL_SIZE - 1;
        return wr_tab[c] ? int'(pre_tab[c]) : 0;
    endfunction

    function automatic logic [7:0] suffix_of(int c);
        c &= TBL_SIZE - 1;
        if (wr_tab[c]) return suf_tab[c];
        return (c < (1 << eff_size())) ? c[7:0] : 8'd0;
    endfunction

    task automatic decode_pull(output pixel_result_t r);
        int clr, w, code, in_c, c, p;
        bit busy, ok;
        r = '{pix: 8'd0, st: STAT_PIXEL};
        if (stk_cnt > 0) begin
            stk_cnt--;
            r.pix = pix_stk[stk_cnt];
        end else if (stream_done) begin
            r.st = STAT_END_CODE;
        end else begin
            busy = 1'b1;
            while (busy) begin
                clr = 1 << eff_size();
                w = code_w;
                if (bits_held < w) begin
                    r.st = term_seen ? STAT_EXHAUSTED : STAT_NEED_DATA;
                    busy = 1'b0;
                end else begin
                    code = bit_buf & ((1 << w) - 1);
                    bit_buf = bit_buf >> w;
                    bits_held -= w;
                    if (code == clr) begin
                        table_clear();
                    end else if (code == clr + 1) begin
                        stream_done = 1'b1;
                        r.st = STAT_END_CODE;
                        busy = 1'b0;
                    end else if (await_first) begin
                        await_first = 1'b0;
                        first_ch = code[7:0];
                        prev_code = code;
                        r.pix = first_ch;
                        busy = 1'b0;
                    end else begin
                        in_c = code;
                        c = code;
                        ok = 1'b1;
                        // A code not yet in the table repeats the previous string plus its head.
                        if (c >= next_free) begin
                            void'(stack_put(first_ch));
                            c = prev_code;
                        end
                        while (ok && c >= clr) begin
                            p = prefix_of(c);
                            if (!stack_put(suffix_of(c)) || p == (c & (TBL_SIZE - 1))) ok = 1'b0;
                            else c = p;
                        end
                        if (ok) begin
                            first_ch = suffix_of(c);
                            ok = stack_put(first_ch);
                        end
                        if (!ok) begin
                            stk_cnt = 0;
                            r.st = STAT_CIRCULAR;
                        end else begin
                            if (next_free < TBL_SIZE) begin
                                pre_tab[next_free] = prev_code[11:0];
                                suf_tab[next_free] = first_ch;
                                wr_tab[next_free] = 1'b1;
                                next_free++;
                                if (next_free >= width_lim && width_lim < TBL_SIZE) begin
                                    width_lim *= 2;
                                    code_w++;
                                end
                            end
                            prev_code = in_c;
                            stk_cnt--;
                            r.pix = pix_stk[stk_cnt];
                        end
                        busy = 1'b0;
                    end
                end
            end
        end
    endtask

    task automatic decode_item(input logic [1:0] cmd, input logic [7:0] b,
                               output pixel_result_t r);
        r = '{pix: 8'd0, st: STAT_ACCEPTED};
        if (cmd == CMD_PUSH) begin
            if (!term_seen) begin
                if (blk_left == 0) begin
                    if (b == 8'd0) term_seen = 1'b1;
                    else blk_left = b;
                end else if (bits_held > 16) begin
                    r.st = STAT_REJECTED;
                end else begin
                    bit_buf = (bit_buf | (int'(b) << bits_held)) & 24'hFFFFFF;
                    bits_held += 8;
                    blk_left--;
                end
            end
        end else if (cmd == CMD_PULL) begin
            decode_pull(r);
        end else if (cmd == CMD_START) begin
            image_start();
        end else begin
            r.st = STAT_REJECTED;
        end
    endtask

    // Predicts at issue time; items are accepted in issue order, so the state matches.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] b, input bit typed,
                             input pixel_result_t want, output status_t got);
        pixel_result_t r;
        decode_item(cmd, b, r);
        pixel_q.push_back(typed ? want : r);
        got = r.st;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, b, cmd};
        do @(posedge clk); while (!s_tready);
        items++;
        @(negedge clk);
    endtask

    task automatic settle_and_config(input logic [3:0] v);
        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        min_size = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR result %0d: %s got %0d expected %0d", results, what, got, want);
        fails++;
    endtask

    always @(posedge clk) begin
        pixel_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pixel_q.size() == 0) begin
                report_mismatch("unexpected result, status", m_tdata[10:8], -1);
            end else begin
                want = pixel_q.pop_front();
                if (m_tdata[10:8] !== want.st) report_mismatch("status", m_tdata[10:8], want.st);
                if (m_tdata[7:0] !== want.pix) report_mismatch("pixel", m_tdata[7:0], want.pix);
                if (m_tdata[15:11] !== 5'd0) report_mismatch("pad bits", m_tdata[15:11], 0);
            end
            results++;
        end
    end

    // The receiver alternates between always ready, light stalls and heavy stalls.
    always @(negedge clk) begin
        int mode;
        mode = (cycles / 300) % 3;
        if (mode == 0) m_tready <= 1'b1;
        else if (mode == 1) m_tready <= ($urandom_range(0, 3) != 0);
        else m_tready <= ($urandom_range(0, 3) == 0);
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("gif_lzw_decoder_unit: mismatch");
            $finish;
        end
    end

    // Builds one image as sub-block bytes from a legal code sequence.
    task automatic build_image(ref logic [7:0] bytes_q[$]);
        logic [7:0] payload[$];
        longint acc;
        int nbits, clr, w, nf, lim, ncodes, code, r, chunk, pos;
        bit first;
        clr = 1 << eff_size();
        w = eff_size() + 1;
        nf = clr + 2;
        lim = 2 * clr;
        first = 1'b1;
        acc = 0;
        nbits = 0;
        ncodes = $urandom_range(8, 50);
        for (int k = 0; k <= ncodes; k++) begin
            r = $urandom_range(0, 99);
            if (k == ncodes) code = (r < 85) ? clr + 1 : -1;
            else if ((k == 0 && r < 50) || (!first && r < 5)) code = clr;
            else if (first) code = $urandom_range(0, clr - 1);
            else if (r < 25 && nf < TBL_SIZE) code = nf;
            else if (r < 60 || nf <= clr + 2) code = $urandom_range(0, clr - 1);
            else code = $urandom_range(clr + 2, nf - 1);
            if (code >= 0) begin
                acc |= longint'(code) << nbits;
                nbits += w;
                while (nbits >= 8) begin
                    payload.push_back(acc[7:0]);
                    acc >>= 8;
                    nbits -= 8;
                end
                if (code == clr) begin
                    w = eff_size() + 1;
                    nf = clr + 2;
                    lim = 2 * clr;
                    first = 1'b1;
                end else if (first) begin
                    first = 1'b0;
                end else if (nf < TBL_SIZE) begin
                    nf++;
                    if (nf >= lim && lim < TBL_SIZE) begin
                        lim *= 2;
                        w++;
                    end
                end
            end
        end
        if (nbits > 0) payload.push_back(acc[7:0]);
        pos = 0;
        while (pos < payload.size()) begin
            chunk = $urandom_range(1, 30);
            if (chunk > payload.size() - pos) chunk = payload.size() - pos;
            bytes_q.push_back(chunk[7:0]);
            for (int i = 0; i < chunk; i++) bytes_q.push_back(payload[pos + i]);
            pos += chunk;
        end
        bytes_q.push_back(8'd0);
    endtask

    initial begin
        dir_row_t dir_tab[22];
        logic [7:0] stream_q[$];
        logic [3:0] size_list[5];
        pixel_result_t none;
        status_t got;
        int r, guard;
        bit image_over;

        none = '{pix: 8'd0, st: STAT_PIXEL};
        // Minimum code size 8: clear, literal 255, literal 0, end, packed as 9-bit codes.
        dir_tab = '{
            '{CMD_PULL,  8'h00, 1, '{8'h00, STAT_NEED_DATA}},
            '{CMD_BAD,   8'hFF, 1, '{8'h00, STAT_REJECTED}},
            '{CMD_PUSH,  8'h05, 1, '{8'h00, STAT_ACCEPTED}},
            '{CMD_PUSH,  8'h00, 1, '{8'h00, STAT_ACCEPTED}},
            '{CMD_PUSH,  8'hFF, 1, '{8'h00, STAT_ACCEPTED}},
            '{CMD_PUSH,  8'h01, 1, '{8'h00, STAT_ACCEPTED}},
            '{CMD_PUSH,  8'h08, 1, '{8'h00, STAT_REJECTED}},
            '{CMD_PULL,  8'hFF, 1, '{8'hFF, STAT_PIXEL}},
            '{CMD_PULL,  8'h00, 1, '{8'h00, STAT_NEED_DATA}},
            '{CMD_PUSH,  8'h08, 1, '{8'h00, STAT_ACCEPTED}},
            '{CMD_PUSH,  8'h08, 1, '{8'h00, STAT_ACCEPTED}},
            '{CMD_PULL,  8'h00, 1, '{8'h00, STAT_PIXEL}},
            '{CMD_PULL,  8'h00, 1, '{8'h00, STAT_END_CODE}},
            '{CMD_PULL,  8'hA5, 0, '{8'h00, STAT_PIXEL}},
            '{CMD_PUSH,  8'h00, 1, '{8'h00, STAT_ACCEPTED}},
            '{CMD_PUSH,  8'h55, 1, '{8'h00, STAT_ACCEPTED}},
            '{CMD_START, 8'h00, 1, '{8'h00, STAT_ACCEPTED}},
            '{CMD_PULL,  8'h00, 1, '{8'h00, STAT_NEED_DATA}},
            '{CMD_PUSH,  8'h01, 1, '{8'h00, STAT_ACCEPTED}},
            '{CMD_PUSH,  8'hAA, 1, '{8'h00, STAT_ACCEPTED}},
            '{CMD_PUSH,  8'h00, 1, '{8'h00, STAT_ACCEPTED}},
            '{CMD_PULL,  8'h00, 1, '{8'h00, STAT_EXHAUSTED}}
        };
        size_list = '{4'd2, 4'd8, 4'd0, 4'd15, 4'd1};

        min_size = 4'd8;
        for (int i = 0; i < TBL_SIZE; i++) begin
            pre_tab[i] = '0;
            suf_tab[i] = '0;
            pix_stk[i] = '0;
        end
        image_start();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[i]) send_item(dir_tab[i].cmd, dir_tab[i].data, dir_tab[i].typed,
                                       dir_tab[i].res, got);

        while (items < ITEM_GOAL) begin
            settle_and_config(images < 5 ? size_list[images] : 4'($urandom_range(2, 8)));
            images++;
            stream_q.delete();
            build_image(stream_q);
            send_item(CMD_START, 8'($urandom), 0, none, got);
            if ($urandom_range(0, 3) == 0) send_item(CMD_PULL, 8'($urandom), 0, none, got);
            image_over = 1'b0;
            guard = 0;
            while (!image_over && guard < 5000) begin
                guard++;
                r = $urandom_range(0, 99);
                if (r == 99) begin
                    send_item(CMD_BAD, 8'($urandom), 0, none, got);
                end else if (stream_q.size() > 0 && (r < 35 || got == STAT_NEED_DATA)) begin
                    if (bits_held > 16 && r >= 8) begin
                        send_item(CMD_PULL, 8'($urandom), 0, none, got);
                    end else begin
                        send_item(CMD_PUSH, stream_q[0], 0, none, got);
                        if (got != STAT_REJECTED) void'(stream_q.pop_front());
                    end
                end else begin
                    send_item(CMD_PULL, 8'($urandom), 0, none, got);
                    if (stream_q.size() == 0 &&
                        (got == STAT_END_CODE || got == STAT_EXHAUSTED)) image_over = 1'b1;
                end
            end
            // Bytes after the terminator are taken and dropped.
            if ($urandom_range(0, 1) == 0) send_item(CMD_PUSH, 8'($urandom), 0, none, got);
        end

        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Ran %0d items over %0d images with code sizes 2 to 8 and clamped settings,",
                 items, images);
        $display("checking %0d results under bursty input and stalled output.", results);
        if (fails == 0) $display("gif_lzw_decoder_unit: match");
        else $display("gif_lzw_decoder_unit: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
